/* hdl/rtns_pkg.sv */
package rtns_pkg;

   localparam int CoordWidth = 24;
   localparam int SizeWidth = 16;
   localparam int IdWidth = 32;
   localparam int CenterWidth = CoordWidth + 1;
   localparam int DiffWidth = CenterWidth + 1;
   localparam int DistWidth = DiffWidth + 1;
   localparam int SqWidth = 2 * DiffWidth + 1;

   localparam logic [1:0] REQ_ADD = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_NEAREST = 2'd2;
   localparam logic [1:0] REQ_RADIUS = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [IdWidth-1:0] rect_id;
      logic signed [CoordWidth-1:0] pos_x;
      logic signed [CoordWidth-1:0] pos_y;
      logic [SizeWidth-1:0] rect_width;
      logic [SizeWidth-1:0] rect_height;
      logic [CoordWidth-1:0] search_radius;
   } cmd_type;

endpackage

/* hdl/rect_table_nearest_search_top.sv */
// Rectangle table with nearest (Manhattan) and radius (Euclidean) search over
// rectangle centers. The back end takes a request from the queue, scans every
// slot, drains the three-stage distance pipeline and then reports. A one-entry
// queue lets start be taken while the previous request is still scanning.
// Results come at most one per cycle on rsp_strobe and the receiver cannot
// stall them; rsp_last marks the final result of each request.
module rect_table_nearest_search_top #(
   parameter int TABLE_DEPTH = 16
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_type,
   input logic [31:0] req_rect_id,
   input logic signed [23:0] req_pos_x,
   input logic signed [23:0] req_pos_y,
   input logic [15:0] req_rect_width,
   input logic [15:0] req_rect_height,
   input logic [23:0] req_search_radius,
   output logic rsp_strobe,
   output logic [31:0] rsp_result_id,
   output logic rsp_found,
   output logic [1:0] rsp_status,
   output logic rsp_last
);
   import rtns_pkg::*;

   cmd_type cmd, q_in, q_head;
   logic q_full, q_push, q_pop;

   assign cmd = '{kind: req_type, rect_id: req_rect_id, pos_x: req_pos_x,
                  pos_y: req_pos_y, rect_width: req_rect_width,
                  rect_height: req_rect_height, search_radius: req_search_radius};

   rtns_front u_front (.req_start(start), .req_cmd(cmd),
                       .q_full, .busy, .q_push, .q_data(q_in));

   rtns_queue u_queue (.clock, .reset, .push(q_push), .push_data(q_in),
                       .pop(q_pop), .full(q_full), .head(q_head));

   rtns_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock, .reset, .q_valid(q_full), .q_head, .q_pop,
      .rsp_strobe, .rsp_result_id, .rsp_found, .rsp_status, .rsp_last);

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full && !q_pop |=> q_full) else $error("queue entry lost");
   a_status_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> !rsp_found && rsp_last)
      else $error("error status with found");
   a_found_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_last) else $error("empty answer not last");
endmodule

/* hdl/rtns_front.sv */
module rtns_front (
   input logic req_start,
   input rtns_pkg::cmd_type req_cmd,
   input logic q_full,
   output logic busy,
   output logic q_push,
   output rtns_pkg::cmd_type q_data
);
   import rtns_pkg::*;

   // One-entry queue to the back end; front accepts whenever it is empty.
   assign busy = q_full;
   assign q_push = req_start && !q_full;
   assign q_data = req_cmd;
endmodule

/* hdl/rtns_queue.sv */
module rtns_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input rtns_pkg::cmd_type push_data,
   input logic pop,
   output logic full,
   output rtns_pkg::cmd_type head
);
   import rtns_pkg::*;

   logic full_ff, full_in;
   cmd_type data_ff;

   always_comb begin
      full_in = full_ff;
      if (pop) full_in = 1'b0;
      if (push) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      if (push) data_ff <= push_data;
   end

   assign full = full_ff;
   assign head = data_ff;
endmodule

/* hdl/rtns_back.sv */
module rtns_back #(
   parameter int TABLE_DEPTH = 16
) (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input rtns_pkg::cmd_type q_head,
   output logic q_pop,
   output logic rsp_strobe,
   output logic [rtns_pkg::IdWidth-1:0] rsp_result_id,
   output logic rsp_found,
   output logic [1:0] rsp_status,
   output logic rsp_last
);
   import rtns_pkg::*;

   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int CntW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CALC, S_DONE} state_type;

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [IdWidth-1:0] id_mem [TABLE_DEPTH];
   logic signed [CoordWidth-1:0] x_mem [TABLE_DEPTH];
   logic signed [CoordWidth-1:0] y_mem [TABLE_DEPTH];
   logic [SizeWidth-1:0] w_mem [TABLE_DEPTH];
   logic [SizeWidth-1:0] h_mem [TABLE_DEPTH];

   state_type state_ff;
   cmd_type cmd_ff;
   logic [CntW-1:0] idx_ff;
   logic match_ff, free_ff, have_ff, emit_ff;
   logic [IdxW-1:0] match_slot_ff, free_slot_ff;
   logic [DistWidth-1:0] best_ff;
   logic [IdWidth-1:0] best_id_ff;
   logic [SqWidth-1:0] dx2_ff, dy2_ff, r2_ff;
   logic rd_valid_ff;
   logic [IdWidth-1:0] rd_id_ff;
   logic [DistWidth-1:0] rd_dist_ff;
   logic [DiffWidth-1:0] rd_dx_ff, rd_dy_ff;
   logic pend_ff;
   logic [IdWidth-1:0] emit_id_ff, pend_hit_id_ff;
   logic strobe_ff, found_ff, last_ff;
   logic [IdWidth-1:0] rid_ff;
   logic [1:0] status_ff;

   logic [IdxW-1:0] idx;
   logic signed [CenterWidth-1:0] cx, cy;
   logic signed [DiffWidth-1:0] sdx, sdy;
   logic [DiffWidth-1:0] adx, ady;
   assign idx = idx_ff[IdxW-1:0];

   always_comb begin
      cx = CenterWidth'(x_mem[idx]) + CenterWidth'(signed'({1'b0, w_mem[idx][SizeWidth-1:1]}));
      cy = CenterWidth'(y_mem[idx]) + CenterWidth'(signed'({1'b0, h_mem[idx][SizeWidth-1:1]}));
      sdx = DiffWidth'(cx) - DiffWidth'(cmd_ff.pos_x);
      sdy = DiffWidth'(cy) - DiffWidth'(cmd_ff.pos_y);
      adx = sdx[DiffWidth-1] ? DiffWidth'(-sdx) : DiffWidth'(sdx);
      ady = sdy[DiffWidth-1] ? DiffWidth'(-sdy) : DiffWidth'(sdy);
   end

   assign q_pop = (state_ff == S_IDLE) && q_valid;

   // Pipeline: scan read (rd_*), square stage (dx2/dy2), compare + pending emit.
   always_ff @(posedge clock) begin
      strobe_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
         emit_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               rd_valid_ff <= 1'b0;
               emit_ff <= 1'b0;
               pend_ff <= 1'b0;
               if (q_valid) begin
                  cmd_ff <= q_head;
                  idx_ff <= '0;
                  match_ff <= 1'b0;
                  free_ff <= 1'b0;
                  have_ff <= 1'b0;
                  r2_ff <= SqWidth'(q_head.search_radius) * SqWidth'(q_head.search_radius);
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               rd_valid_ff <= valid_ff[idx];
               rd_id_ff <= id_mem[idx];
               rd_dist_ff <= DistWidth'(adx) + DistWidth'(ady);
               rd_dx_ff <= adx;
               rd_dy_ff <= ady;
               if (valid_ff[idx] && id_mem[idx] == cmd_ff.rect_id && !match_ff) begin
                  match_ff <= 1'b1;
                  match_slot_ff <= idx;
               end
               if (!valid_ff[idx] && !free_ff) begin
                  free_ff <= 1'b1;
                  free_slot_ff <= idx;
               end
               if (idx_ff == CntW'(TABLE_DEPTH - 1)) state_ff <= S_CALC;
               idx_ff <= idx_ff + 1'b1;
            end
            S_CALC: begin
               rd_valid_ff <= 1'b0;
               if (!rd_valid_ff && !emit_ff) state_ff <= S_DONE;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
               strobe_ff <= 1'b1;
               last_ff <= 1'b1;
               status_ff <= ST_OK;
               unique case (cmd_ff.kind)
                  REQ_ADD: begin
                     if (match_ff || free_ff) begin
                        valid_ff[match_ff ? match_slot_ff : free_slot_ff] <= 1'b1;
                        rid_ff <= cmd_ff.rect_id;
                        found_ff <= 1'b1;
                     end else begin
                        rid_ff <= '0;
                        found_ff <= 1'b0;
                        status_ff <= ST_FULL;
                     end
                  end
                  REQ_REMOVE: begin
                     if (match_ff) begin
                        valid_ff[match_slot_ff] <= 1'b0;
                        rid_ff <= cmd_ff.rect_id;
                        found_ff <= 1'b1;
                     end else begin
                        rid_ff <= '0;
                        found_ff <= 1'b0;
                        status_ff <= ST_ABSENT;
                     end
                  end
                  REQ_NEAREST: begin
                     rid_ff <= have_ff ? best_id_ff : '0;
                     found_ff <= have_ff;
                  end
                  default: begin
                     if (pend_ff) begin
                        rid_ff <= pend_hit_id_ff;
                        found_ff <= 1'b1;
                     end else begin
                        rid_ff <= '0;
                        found_ff <= 1'b0;
                     end
                  end
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase

         if (state_ff == S_SCAN || state_ff == S_CALC) begin
            emit_ff <= rd_valid_ff;
            if (rd_valid_ff) begin
               dx2_ff <= SqWidth'(rd_dx_ff) * SqWidth'(rd_dx_ff);
               dy2_ff <= SqWidth'(rd_dy_ff) * SqWidth'(rd_dy_ff);
               if (!have_ff || rd_dist_ff < best_ff) begin
                  have_ff <= 1'b1;
                  best_ff <= rd_dist_ff;
                  best_id_ff <= rd_id_ff;
               end
            end
         end
         if (cmd_ff.kind == REQ_RADIUS && (state_ff == S_SCAN || state_ff == S_CALC)
             && emit_ff && (dx2_ff + dy2_ff <= r2_ff)) begin
            // hold one hit back so the final one can carry last
            if (pend_ff) begin
               strobe_ff <= 1'b1;
               rid_ff <= pend_hit_id_ff;
               found_ff <= 1'b1;
               status_ff <= ST_OK;
               last_ff <= 1'b0;
            end
            pend_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) emit_id_ff <= rd_id_ff;
      if (cmd_ff.kind == REQ_RADIUS && emit_ff && (dx2_ff + dy2_ff <= r2_ff))
         pend_hit_id_ff <= emit_id_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && cmd_ff.kind == REQ_ADD && (match_ff || free_ff)) begin
         id_mem[match_ff ? match_slot_ff : free_slot_ff] <= cmd_ff.rect_id;
         x_mem[match_ff ? match_slot_ff : free_slot_ff] <= cmd_ff.pos_x;
         y_mem[match_ff ? match_slot_ff : free_slot_ff] <= cmd_ff.pos_y;
         w_mem[match_ff ? match_slot_ff : free_slot_ff] <= cmd_ff.rect_width;
         h_mem[match_ff ? match_slot_ff : free_slot_ff] <= cmd_ff.rect_height;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_result_id = rid_ff;
   assign rsp_found = found_ff;
   assign rsp_status = status_ff;
   assign rsp_last = last_ff;
endmodule

/* tb/testbench.sv */
module testbench;
   import rtns_pkg::*;

   typedef struct {
      logic [31:0] result_id;
      logic found;
      logic [1:0] status;
      logic last;
   } rsp_item_type;

   class rect_table_scoreboard;
      bit valid_q[16];
      logic [31:0] id_q[16];
      longint x_q[16];
      longint y_q[16];
      longint w_q[16];
      longint h_q[16];
      rsp_item_type expected_rsps[$];
      int mismatches;

      function int find_id(logic [31:0] id);
         for (int i = 0; i < 16; i++)
            if (valid_q[i] && id_q[i] == id) return i;
         return -1;
      endfunction

      function void push(logic [31:0] id, logic f, logic [1:0] st, logic l);
         rsp_item_type e;
         e.result_id = id;
         e.found = f;
         e.status = st;
         e.last = l;
         expected_rsps = {expected_rsps, e};
      endfunction

      function void note_request(logic [1:0] kind, logic [31:0] id,
            logic signed [23:0] px, logic signed [23:0] py,
            logic [15:0] w, logic [15:0] h, logic [23:0] r);
         int s;
         int n;
         longint cx, cy, dx, dy, d, best, rr;
         bit have;
         logic [31:0] best_id;
         if (kind == REQ_ADD) begin
            s = find_id(id);
            if (s < 0)
               for (int i = 0; i < 16; i++)
                  if (!valid_q[i]) begin
                     s = i;
                     break;
                  end
            if (s < 0) begin
               push('0, 1'b0, ST_FULL, 1'b1);
            end else begin
               valid_q[s] = 1'b1;
               id_q[s] = id;
               x_q[s] = px;
               y_q[s] = py;
               w_q[s] = w;
               h_q[s] = h;
               push(id, 1'b1, ST_OK, 1'b1);
            end
         end else if (kind == REQ_REMOVE) begin
            s = find_id(id);
            if (s < 0) push('0, 1'b0, ST_ABSENT, 1'b1);
            else begin
               valid_q[s] = 1'b0;
               push(id, 1'b1, ST_OK, 1'b1);
            end
         end else begin
            have = 1'b0;
            best = 0;
            best_id = '0;
            n = 0;
            rr = longint'(r) * longint'(r);
            for (int i = 0; i < 16; i++) begin
               if (!valid_q[i]) continue;
               cx = x_q[i] + w_q[i] / 2;
               cy = y_q[i] + h_q[i] / 2;
               dx = cx > px ? cx - px : px - cx;
               dy = cy > py ? cy - py : py - cy;
               if (kind == REQ_NEAREST) begin
                  d = dx + dy;
                  if (!have || d < best) begin
                     have = 1'b1;
                     best = d;
                     best_id = id_q[i];
                  end
               end else if (dx * dx + dy * dy <= rr) begin
                  push(id_q[i], 1'b1, ST_OK, 1'b0);
                  n++;
               end
            end
            if (kind == REQ_NEAREST) push(best_id, have, ST_OK, 1'b1);
            else if (n == 0) push('0, 1'b0, ST_OK, 1'b1);
            else expected_rsps[$].last = 1'b1;
         end
      endfunction

      function void check_rsp(rsp_item_type a);
         rsp_item_type e;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: id=%h found=%b status=%0d last=%b",
                  a.result_id, a.found, a.status, a.last);
            return;
         end
         e = expected_rsps.pop_front();
         if (e.result_id !== a.result_id || e.found !== a.found ||
               e.status !== a.status || e.last !== a.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp id=%h found=%b status=%0d last=%b, ",
                  "got id=%h found=%b status=%0d last=%b"},
                  e.result_id, e.found, e.status, e.last,
                  a.result_id, a.found, a.status, a.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_type = '0;
   logic [31:0] req_rect_id = '0;
   logic signed [23:0] req_pos_x = '0;
   logic signed [23:0] req_pos_y = '0;
   logic [15:0] req_rect_width = '0;
   logic [15:0] req_rect_height = '0;
   logic [23:0] req_search_radius = '0;
   logic rsp_strobe;
   logic [31:0] rsp_result_id;
   logic rsp_found;
   logic [1:0] rsp_status;
   logic rsp_last;

   rect_table_nearest_search_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rect_table_scoreboard table_sb = new();
   int sender_idle_pct = 0;
   int stall_cycles = 0;
   logic [31:0] used_ids[$];

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            stall_cycles <= 0;
            table_sb.note_request(req_type, req_rect_id, req_pos_x, req_pos_y,
               req_rect_width, req_rect_height, req_search_radius);
         end else if (rsp_strobe) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (rsp_strobe)
            table_sb.check_rsp('{rsp_result_id, rsp_found, rsp_status, rsp_last});
      end
   end

   always @(posedge clock)
      if (stall_cycles > 4000) begin
         $display("rect_table_nearest_search_top test failed");
         $finish;
      end

   task automatic send(logic [1:0] kind, logic [31:0] id, logic signed [23:0] px,
         logic signed [23:0] py, logic [15:0] w, logic [15:0] h, logic [23:0] r);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_rect_id <= id;
      req_pos_x <= px;
      req_pos_y <= py;
      req_rect_width <= w;
      req_rect_height <= h;
      req_search_radius <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'(int'($urandom_range(2000)) - 1000);
         2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
         default: return 24'(int'($urandom_range(200000)) - 100000);
      endcase
   endfunction

   function automatic logic [31:0] rand_id();
      if (used_ids.size() > 0 && $urandom_range(2) != 0)
         return used_ids[$urandom_range(used_ids.size() - 1)];
      rand_id = $urandom_range(3) == 0 ? $urandom : $urandom_range(40);
      used_ids = {used_ids, rand_id};
   endfunction

   task automatic random_item();
      int k;
      k = $urandom_range(99);
      if (k < 40)
         send(REQ_ADD, rand_id(), rand_coord(), rand_coord(),
            16'($urandom_range(1) ? $urandom : $urandom_range(100)),
            16'($urandom_range(1) ? $urandom : $urandom_range(100)), 24'($urandom));
      else if (k < 60)
         send(REQ_REMOVE, rand_id(), 24'($urandom), 24'($urandom), 16'($urandom),
            16'($urandom), 24'($urandom));
      else if (k < 78)
         send(REQ_NEAREST, $urandom, rand_coord(), rand_coord(), 16'($urandom),
            16'($urandom), 24'($urandom));
      else
         send(REQ_RADIUS, $urandom, rand_coord(), rand_coord(), 16'($urandom),
            16'($urandom),
            24'($urandom_range(2) == 0 ? $urandom : $urandom_range(3000)));
   endtask

   initial begin
      int pct[4] = '{0, 47, 0, 36};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(REQ_NEAREST, '0, '0, '0, '0, '0, '0);
      send(REQ_RADIUS, '0, '0, '0, '0, '0, 24'hffffff);
      send(REQ_REMOVE, 32'd5, '0, '0, '0, '0, '0);
      send(REQ_ADD, '0, 24'sh7fffff, 24'sh7fffff, 16'hffff, 16'hffff, '0);
      send(REQ_ADD, 32'hffffffff, 24'sh800000, 24'sh800000, '0, '0, '0);
      send(REQ_NEAREST, '0, 24'sh7fffff, 24'sh7fffff, '0, '0, '0);
      send(REQ_NEAREST, '0, 24'sh800000, 24'sh800000, '0, '0, '0);
      send(REQ_RADIUS, '0, '0, '0, '0, '0, 24'hffffff);
      send(REQ_RADIUS, '0, '0, '0, '0, '0, '0);
      send(REQ_ADD, '0, 24'sd10, 24'sd10, 16'd4, 16'd4, '0);
      for (int i = 1; i <= 15; i++)
         send(REQ_ADD, 32'(i), 24'(i), '0, 16'd2, 16'd2, '0);
      send(REQ_ADD, 32'd99, '0, '0, '0, '0, '0);
      send(REQ_NEAREST, '0, 24'sd5, 24'sd1, '0, '0, '0);
      send(REQ_RADIUS, '0, 24'sd8, 24'sd1, '0, '0, 24'hffffff);
      send(REQ_REMOVE, '0, '0, '0, '0, '0, '0);
      for (int i = 1; i <= 15; i++)
         send(REQ_REMOVE, 32'(i), '0, '0, '0, '0, '0);
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = pct[ph];
         repeat (70) random_item();
      end
      start <= 1'b0;
      while (table_sb.expected_rsps.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (table_sb.mismatches == 0 && table_sb.expected_rsps.size() == 0)
         $display("rect_table_nearest_search_top test passed");
      else
         $display("rect_table_nearest_search_top test failed");
      $finish;
   end
endmodule
